>>> hw/rtl/pid_with_term_limits_unit_assert.svh
// assertion macros for the pid regulator rtl
// included by modules that carry concurrent checks; no other dependencies
`ifndef PID_WITH_TERM_LIMITS_UNIT_ASSERT_SVH
`define PID_WITH_TERM_LIMITS_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PWTL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PWTL_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PWTL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define PWTL_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> hw/rtl/pwtl_pkg.sv
// shared types and constants for the pid regulator with clamped terms
// used by the top level, the register file and the front stage; no dependencies
`default_nettype none
package pwtl_pkg;

  localparam int FracBitsDefault = 16;
  localparam int CfgIndexWidth   = 8;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_PROP_GAIN         = 8'd0,
    REG_INTEG_GAIN_DT     = 8'd1,
    REG_DERIV_GAIN_RATE   = 8'd2,
    REG_PROP_ERROR_LIMIT  = 8'd3,
    REG_INTEG_SUM_LIMIT   = 8'd4,
    REG_DERIV_DELTA_LIMIT = 8'd5,
    REG_PD_ONLY           = 8'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] prop_gain;
    logic [31:0] integ_gain_dt;
    logic [31:0] deriv_gain_rate;
    logic [30:0] prop_error_limit;
    logic [30:0] integ_sum_limit;
    logic [30:0] deriv_delta_limit;
    logic        pd_only;
  } cfg_t;

  // clamped operands handed from the front stage to the multipliers
  typedef struct packed {
    logic signed [31:0] prop_op;
    logic signed [31:0] integ_op;
    logic signed [31:0] deriv_op;
  } operands_t;

endpackage
`default_nettype wire

>>> hw/rtl/pwtl_cfg_regs.sv
// configuration register file of the pid regulator
// depends on pwtl_pkg for the register index codes and the cfg_t struct
`default_nettype none
module pwtl_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [pwtl_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  wire logic [31:0]                         cfg_data,
  output pwtl_pkg::cfg_t                           cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain         <= '0;
      cfg.integ_gain_dt     <= '0;
      cfg.deriv_gain_rate   <= '0;
      cfg.prop_error_limit  <= '1;
      cfg.integ_sum_limit   <= '1;
      cfg.deriv_delta_limit <= '1;
      cfg.pd_only           <= 1'b0;
    end else if (cfg_valid) begin
      unique case (pwtl_pkg::cfg_reg_t'(cfg_index))
        pwtl_pkg::REG_PROP_GAIN:         cfg.prop_gain         <= cfg_data;
        pwtl_pkg::REG_INTEG_GAIN_DT:     cfg.integ_gain_dt     <= cfg_data;
        pwtl_pkg::REG_DERIV_GAIN_RATE:   cfg.deriv_gain_rate   <= cfg_data;
        pwtl_pkg::REG_PROP_ERROR_LIMIT:  cfg.prop_error_limit  <= cfg_data[30:0];
        pwtl_pkg::REG_INTEG_SUM_LIMIT:   cfg.integ_sum_limit   <= cfg_data[30:0];
        pwtl_pkg::REG_DERIV_DELTA_LIMIT: cfg.deriv_delta_limit <= cfg_data[30:0];
        pwtl_pkg::REG_PD_ONLY:           cfg.pd_only           <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/pwtl_front.sv
// front stage: clamps the error, updates integrator and previous sample
// depends on pwtl_pkg for cfg_t and operands_t
`default_nettype none
module pwtl_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire logic signed [31:0] error_sample,
  input  wire pwtl_pkg::cfg_t     cfg,
  output pwtl_pkg::operands_t     ops
);

  logic signed [31:0] integ_sum;
  logic signed [31:0] integ_sum_next;
  logic signed [31:0] prev_error;
  logic signed [32:0] acc_wide;
  logic signed [32:0] delta_wide;
  pwtl_pkg::operands_t ops_next;

  function automatic logic signed [31:0] clamp_sym(input logic signed [32:0] v,
                                                   input logic [30:0] lim);
    logic signed [32:0] hi;
    logic signed [32:0] lo;
    hi = $signed({2'b00, lim});
    lo = -hi;
    if (v > hi) return hi[31:0];
    else if (v < lo) return lo[31:0];
    else return v[31:0];
  endfunction

  always_comb begin
    acc_wide       = 33'(integ_sum) + 33'(error_sample);
    delta_wide     = 33'(error_sample) - 33'(prev_error);
    integ_sum_next = clamp_sym(acc_wide, cfg.integ_sum_limit);
    ops_next.prop_op  = clamp_sym(33'(error_sample), cfg.prop_error_limit);
    // pd mode feeds zero into the integral multiplier
    ops_next.integ_op = cfg.pd_only ? 32'sd0 : integ_sum_next;
    ops_next.deriv_op = clamp_sym(delta_wide, cfg.deriv_delta_limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ_sum  <= '0;
      prev_error <= '0;
    end else if (load) begin
      if (!cfg.pd_only) begin
        integ_sum <= integ_sum_next;
      end
      prev_error <= error_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ops <= ops_next;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/pwtl_term.sv
// one gain term: multiply, then round to nearest and saturate to 32 bits
// two register stages; depends on nothing but its ports
`default_nettype none
module pwtl_term #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               mul_en,
  input  wire logic               rnd_en,
  input  wire logic [31:0]        gain,
  input  wire logic signed [31:0] operand,
  output logic signed [31:0]      term,
  output logic                    sat
);

  localparam logic signed [64:0] Half = 65'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [64:0] MaxV = 65'sd2147483647;
  localparam logic signed [64:0] MinV = -65'sd2147483648;

  logic signed [63:0] gain_ext;
  logic signed [63:0] op_ext;
  logic signed [63:0] prod;
  logic signed [64:0] rounded;
  logic signed [64:0] scaled;
  logic signed [31:0] term_next;
  logic               sat_next;

  // unsigned gain times signed operand stays well inside 64 bits
  assign gain_ext = $signed({32'd0, gain});
  assign op_ext   = 64'(operand);

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= gain_ext * op_ext;
    end
  end

  always_comb begin
    rounded = 65'(prod) + Half;
    scaled  = rounded >>> FRAC_BITS;
    if (scaled > MaxV) begin
      term_next = 32'sh7FFF_FFFF;
      sat_next  = 1'b1;
    end else if (scaled < MinV) begin
      term_next = 32'sh8000_0000;
      sat_next  = 1'b1;
    end else begin
      term_next = scaled[31:0];
      sat_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rnd_en) begin
      term <= term_next;
      sat  <= sat_next;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/pid_with_term_limits_unit.sv
// top level of the pid regulator with clamped terms
// depends on pwtl_pkg, pwtl_cfg_regs, pwtl_front, pwtl_term and the assertion header
//
// usage:
//   error samples enter on in_valid/in_ready with error_sample; each transfer
//   yields exactly one result on out_valid/out_ready carrying correction, the
//   three terms and the saturated flag.
//   registers are written on cfg_valid/cfg_ready (always ready) with cfg_index
//   and cfg_data; indexes past the list are dropped. write them only while no
//   sample is in flight.
// timing:
//   four-stage pipeline: clamp and state update, multiply, round and
//   saturate, sum and output register. one sample per cycle is taken while
//   the output is not stalled; the integrator add-clamp in the front stage
//   is the only loop.
// stalls and reset:
//   each stage holds its own valid bit, so while the receiver stalls the
//   block keeps taking samples until every stage is full, then drops in_ready.
//   reset clears valid bits, integrator, previous sample and gains; sets limits to all ones.
`default_nettype none
`include "pid_with_term_limits_unit_assert.svh"
module pid_with_term_limits_unit #(
  parameter int FRAC_BITS = pwtl_pkg::FracBitsDefault
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [pwtl_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [31:0]                        cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [31:0]                 error_sample,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [31:0]                      correction,
  output logic signed [31:0]                      prop_term,
  output logic signed [31:0]                      integ_term,
  output logic signed [31:0]                      deriv_term,
  output logic                                    saturated
);

  pwtl_pkg::cfg_t      cfg;
  pwtl_pkg::operands_t ops;

  logic v1, v2, v3;
  logic r1, r2, r3, r4;
  logic load1, load2, load3, load4;

  logic signed [31:0] p_t, i_t, d_t;
  logic               p_s, i_s, d_s;
  logic signed [33:0] sum_wide;
  logic signed [31:0] correction_next;
  logic               saturated_next;

  // per-stage ready so bubbles can close up behind a stalled output
  assign r4 = !out_valid || out_ready;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready = r1;

  assign load1 = in_valid && r1;
  assign load2 = v1 && r2;
  assign load3 = v2 && r3;
  assign load4 = v3 && r4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) out_valid <= v3;
    end
  end

  pwtl_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pwtl_front u_front (
    .clk          (clk),
    .rst          (rst),
    .load         (load1),
    .error_sample (error_sample),
    .cfg          (cfg),
    .ops          (ops)
  );

  pwtl_term #(.FRAC_BITS(FRAC_BITS)) u_prop (
    .clk     (clk),
    .mul_en  (load2),
    .rnd_en  (load3),
    .gain    (cfg.prop_gain),
    .operand (ops.prop_op),
    .term    (p_t),
    .sat     (p_s)
  );

  pwtl_term #(.FRAC_BITS(FRAC_BITS)) u_integ (
    .clk     (clk),
    .mul_en  (load2),
    .rnd_en  (load3),
    .gain    (cfg.integ_gain_dt),
    .operand (ops.integ_op),
    .term    (i_t),
    .sat     (i_s)
  );

  pwtl_term #(.FRAC_BITS(FRAC_BITS)) u_deriv (
    .clk     (clk),
    .mul_en  (load2),
    .rnd_en  (load3),
    .gain    (cfg.deriv_gain_rate),
    .operand (ops.deriv_op),
    .term    (d_t),
    .sat     (d_s)
  );

  always_comb begin
    sum_wide = 34'(p_t) + 34'(i_t) + 34'(d_t);
    saturated_next = p_s || i_s || d_s;
    if (sum_wide > 34'sd2147483647) begin
      correction_next = 32'sh7FFF_FFFF;
      saturated_next  = 1'b1;
    end else if (sum_wide < -34'sd2147483648) begin
      correction_next = 32'sh8000_0000;
      saturated_next  = 1'b1;
    end else begin
      correction_next = sum_wide[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load4) begin
      correction <= correction_next;
      prop_term  <= p_t;
      integ_term <= i_t;
      deriv_term <= d_t;
      saturated  <= saturated_next;
    end
  end

  `PWTL_ASSERT_IMP(a_ready_when_drained, clk, rst, !out_valid, in_ready, "input blocked with empty output")
  `PWTL_ASSERT_IMP(a_rise_from_stage3, clk, rst, $rose(out_valid), $past(v3), "result appeared without a term")
  `PWTL_ASSERT_IMP(a_sum_exact, clk, rst, out_valid && !saturated, 34'(correction) == (34'(prop_term) + 34'(integ_term) + 34'(deriv_term)), "unsaturated sum mismatch")
  `PWTL_ASSERT_NXT(a_stall_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(correction), "stalled result changed")

endmodule
`default_nettype wire
